>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the sorted request queue, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never hold on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/sortq_pkg.sv
// Package with the types and constants of the sorted request queue.
`timescale 1ns / 1ps

package sortq_pkg;

    localparam int TAG_W    = 8;
    localparam int SECTOR_W = 48;
    localparam int COUNT_W  = 16;
    localparam int END_W    = SECTOR_W + 1;

    // Operation codes carried in the kind field of a request beat.
    localparam logic [1:0] KIND_ADD      = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_REMOVE   = 2'd2;

    // What every cell of the chain does at each clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_OUT
    } cell_op_t;

    typedef struct packed {
        logic [END_W-1:0]    end_sector;
        logic [SECTOR_W-1:0] start_sector;
        logic [TAG_W-1:0]    tag;
        logic                is_write;
    } entry_t;

    // Broadcast control that reaches every cell at once.
    typedef struct packed {
        cell_op_t         op;
        logic [END_W-1:0] end_key;
        logic [TAG_W-1:0] tag;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [TAG_W-1:0]    tag;
        logic [SECTOR_W-1:0] start_sector;
        logic [COUNT_W-1:0]  sector_count;
        logic                is_write;
    } req_t;

    typedef struct packed {
        logic                dispatched;
        logic [TAG_W-1:0]    out_tag;
        logic [SECTOR_W-1:0] out_start_sector;
        logic                out_is_write;
        logic                full_reject;
        logic                tag_missing;
        logic                queue_empty;
    } rsp_t;

endpackage

>>> hw/rtl/sortq_cell.sv
// One cell of the sorted chain: holds one entry and moves it to or from its neighbors.
`timescale 1ns / 1ps

module sortq_cell (
    input  logic                clk,
    input  sortq_pkg::cell_ctrl_t ctrl,
    input  sortq_pkg::entry_t   new_entry,
    input  sortq_pkg::entry_t   left_entry,
    input  sortq_pkg::entry_t   right_entry,
    input  logic                occupied,
    input  logic                mark_left,
    input  logic                hit_in,
    output logic                mark,
    output logic                hit_out,
    output sortq_pkg::entry_t   entry
);

    sortq_pkg::entry_t entry_reg;
    sortq_pkg::entry_t entry_next;

    // An insert lands at or before this cell when the cell is free or holds a larger key.
    // The match chain marks every cell at or after the first entry to leave.
    always_comb
    begin
        mark       = 1'b0;
        hit_out    = hit_in;
        entry_next = entry_reg;
        unique case (ctrl.op)
            sortq_pkg::CELL_INSERT:
            begin
                mark = !occupied || (ctrl.end_key < entry_reg.end_sector);
                if (mark)
                begin
                    entry_next = mark_left ? left_entry : new_entry;
                end
            end
            sortq_pkg::CELL_SHIFT_OUT:
            begin
                hit_out = hit_in || (occupied && (entry_reg.tag == ctrl.tag));
                if (hit_out)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> hw/rtl/sorted_request_queue_top.sv
// Top level of the sorted request queue: cell chain, occupancy count and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The queue keeps up to DEPTH disk requests in a chain of cells, sorted by end
// sector (start sector plus sector count, 49 bits, no wrap). Requests with equal
// end sectors leave in arrival order. Each request beat is one operation: an add
// inserts a request, a dispatch pops the entry with the lowest end sector, and a
// remove drops the first entry that carries the given tag. Every request beat
// produces exactly one response beat, which holds the popped entry on a dispatch
// (zeros otherwise), a flag for an add refused on a full queue, a flag for a
// remove whose tag is absent, and whether the queue is empty after the step.
// Unused kind code 3 changes nothing. For every operation, all cells compare
// against the broadcast key or tag in parallel and move one place left or right
// at the same edge, so the cycle time is set by one 49-bit compare per cell plus
// the ripple of the tag-match chain across the cells. A new request beat is taken
// in every cycle in which the response register is empty or its beat is being
// taken, so the sustained rate is one operation per cycle; the response is
// registered and appears in the cycle after the request is taken. There is no
// clearing pass after reset; cells beyond the occupancy are never read.
module sorted_request_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sortq_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output sortq_pkg::rsp_t   rsp
);

    localparam int OCC_W = $clog2(DEPTH + 1);

    logic                   req_fire;
    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    sortq_pkg::rsp_t        rsp_reg;
    sortq_pkg::rsp_t        rsp_next;
    sortq_pkg::cell_ctrl_t  ctrl;
    sortq_pkg::entry_t      new_entry;
    logic                   is_full;
    logic                   is_empty;
    logic                   head_hit;
    logic                   found;

    sortq_pkg::entry_t      cell_entry [DEPTH];
    logic [DEPTH-1:0]       cell_occ;
    logic [DEPTH-1:0]       cell_mark;
    logic [DEPTH-1:0]       cell_hit;

    assign req_fire = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign is_full  = (occ_reg == OCC_W'(DEPTH));
    assign is_empty = (occ_reg == '0);

    // The entry that an add would write, with its end sector as the sort key.
    always_comb
    begin
        new_entry.end_sector   = {1'b0, req.start_sector}
                                 + {{(sortq_pkg::END_W - sortq_pkg::COUNT_W){1'b0}},
                                    req.sector_count};
        new_entry.start_sector = req.start_sector;
        new_entry.tag          = req.tag;
        new_entry.is_write     = req.is_write;
    end

    // Decide the operation that all cells perform in this cycle. A dispatch is a
    // shift out with the match chain forced on from the head cell.
    always_comb
    begin
        ctrl.op      = sortq_pkg::CELL_HOLD;
        ctrl.end_key = new_entry.end_sector;
        ctrl.tag     = req.tag;
        head_hit     = 1'b0;
        if (req_fire)
        begin
            unique case (req.kind)
                sortq_pkg::KIND_ADD:
                begin
                    if (!is_full)
                    begin
                        ctrl.op = sortq_pkg::CELL_INSERT;
                    end
                end
                sortq_pkg::KIND_DISPATCH:
                begin
                    head_hit = 1'b1;
                    if (!is_empty)
                    begin
                        ctrl.op = sortq_pkg::CELL_SHIFT_OUT;
                    end
                end
                sortq_pkg::KIND_REMOVE:
                begin
                    ctrl.op = sortq_pkg::CELL_SHIFT_OUT;
                end
                default:
                begin
                    ctrl.op = sortq_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // The chain of cells. The left neighbor of the head is the new entry; the tail
    // refills from itself on a shift out, which leaves it beyond the occupancy.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sortq_pkg::entry_t left_entry;
        sortq_pkg::entry_t right_entry;
        logic              mark_left;
        logic              hit_in;

        if (i == 0)
        begin : g_head
            assign left_entry = new_entry;
            assign mark_left  = 1'b0;
            assign hit_in     = head_hit;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign mark_left  = cell_mark[i-1];
            assign hit_in     = cell_hit[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        assign cell_occ[i] = (OCC_W'(i) < occ_reg);

        sortq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .occupied    (cell_occ[i]),
            .mark_left   (mark_left),
            .hit_in      (hit_in),
            .mark        (cell_mark[i]),
            .hit_out     (cell_hit[i]),
            .entry       (cell_entry[i])
        );
    end

    // On a shift out, the last cell of the match chain tells whether any entry left the queue.
    assign found = cell_hit[DEPTH-1];

    always_comb
    begin
        occ_next = occ_reg;
        unique case (ctrl.op)
            sortq_pkg::CELL_INSERT:
            begin
                occ_next = occ_reg + OCC_W'(1);
            end
            sortq_pkg::CELL_SHIFT_OUT:
            begin
                if (found)
                begin
                    occ_next = occ_reg - OCC_W'(1);
                end
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    // Response beat for the request taken in this cycle.
    always_comb
    begin
        rsp_next                  = '0;
        rsp_next.dispatched       = (req.kind == sortq_pkg::KIND_DISPATCH) && !is_empty;
        if (rsp_next.dispatched)
        begin
            rsp_next.out_tag          = cell_entry[0].tag;
            rsp_next.out_start_sector = cell_entry[0].start_sector;
            rsp_next.out_is_write     = cell_entry[0].is_write;
        end
        rsp_next.full_reject      = (req.kind == sortq_pkg::KIND_ADD) && is_full;
        rsp_next.tag_missing      = (req.kind == sortq_pkg::KIND_REMOVE) && !found;
        rsp_next.queue_empty      = (occ_next == '0);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (req_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_NEVER(a_occ_bound, clk, rst_n, occ_reg > OCC_W'(DEPTH),
        "occupancy exceeds the queue depth")

    `ASSERT_CLK(a_full_holds, clk, rst_n,
        (req_fire && (req.kind == sortq_pkg::KIND_ADD) && is_full) |=> (occ_reg == OCC_W'(DEPTH)),
        "refused add changed the occupancy")

    `ASSERT_CLK(a_pop_count, clk, rst_n,
        (req_fire && (req.kind == sortq_pkg::KIND_DISPATCH) && !is_empty)
            |=> (occ_reg == $past(occ_reg) - OCC_W'(1)),
        "dispatch did not remove exactly one entry")

    `ASSERT_NEVER(a_flag_excl, clk, rst_n,
        rsp_valid_reg && rsp_reg.dispatched && (rsp_reg.full_reject || rsp_reg.tag_missing),
        "dispatch response carries an add or remove flag")

endmodule

>>> tb/sv/sorted_request_queue_checker.sv
// Checker that mirrors the sorted request queue and compares every response beat.
`timescale 1ns / 1ps

module sorted_request_queue_checker #(
    parameter int DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  sortq_pkg::req_t req,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  sortq_pkg::rsp_t rsp,
    output int              fail_count,
    output int              open_count
);

    typedef struct packed {
        logic [sortq_pkg::END_W-1:0]    end_sector;
        logic [sortq_pkg::SECTOR_W-1:0] start_sector;
        logic [sortq_pkg::TAG_W-1:0]    tag;
        logic                           is_write;
    } slot_t;

    // Mirror of the queue contents, lowest end sector in slot 0.
    slot_t           slots[DEPTH];
    int              held;
    sortq_pkg::rsp_t due_rsp[$];
    int              mismatches;

    function automatic void drop_slot(int pos);
        int i;
        for (i = pos; i + 1 < held; i++)
        begin
            slots[i] = slots[i + 1];
        end
        held--;
    endfunction

    // Applies one request beat to the mirror and returns the response it must produce.
    function automatic sortq_pkg::rsp_t apply_request(sortq_pkg::req_t r);
        sortq_pkg::rsp_t             res;
        logic [sortq_pkg::END_W-1:0] key;
        int                          pos;
        int                          i;
        res = '0;
        case (r.kind)
            sortq_pkg::KIND_ADD:
            begin
                if (held >= DEPTH)
                begin
                    res.full_reject = 1'b1;
                end
                else
                begin
                    key = sortq_pkg::END_W'(r.start_sector)
                          + sortq_pkg::END_W'(r.sector_count);
                    pos = 0;
                    while (pos < held && !(key < slots[pos].end_sector))
                    begin
                        pos++;
                    end
                    for (i = held; i > pos; i--)
                    begin
                        slots[i] = slots[i - 1];
                    end
                    slots[pos].end_sector   = key;
                    slots[pos].start_sector = r.start_sector;
                    slots[pos].tag          = r.tag;
                    slots[pos].is_write     = r.is_write;
                    held++;
                end
            end
            sortq_pkg::KIND_DISPATCH:
            begin
                if (held > 0)
                begin
                    res.dispatched       = 1'b1;
                    res.out_tag          = slots[0].tag;
                    res.out_start_sector = slots[0].start_sector;
                    res.out_is_write     = slots[0].is_write;
                    drop_slot(0);
                end
            end
            sortq_pkg::KIND_REMOVE:
            begin
                pos = 0;
                while (pos < held && slots[pos].tag != r.tag)
                begin
                    pos++;
                end
                if (pos < held)
                begin
                    drop_slot(pos);
                end
                else
                begin
                    res.tag_missing = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.queue_empty = (held == 0);
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Values are taken at the rising edge, before anything driven at that edge settles.
    always @(posedge clk or negedge rst_n)
    begin
        sortq_pkg::rsp_t want;
        if (!rst_n)
        begin
            held = 0;
            due_rsp.delete();
            mismatches = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    $error("response beat with no request beat outstanding");
                    mismatches++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    check_field("dispatched", 64'(want.dispatched), 64'(rsp.dispatched));
                    check_field("out_tag", 64'(want.out_tag), 64'(rsp.out_tag));
                    check_field("out_start_sector", 64'(want.out_start_sector),
                                64'(rsp.out_start_sector));
                    check_field("out_is_write", 64'(want.out_is_write),
                                64'(rsp.out_is_write));
                    check_field("full_reject", 64'(want.full_reject), 64'(rsp.full_reject));
                    check_field("tag_missing", 64'(want.tag_missing), 64'(rsp.tag_missing));
                    check_field("queue_empty", 64'(want.queue_empty), 64'(rsp.queue_empty));
                end
            end
            if (req_valid && req_ready)
            begin
                due_rsp.push_back(apply_request(req));
            end
        end
        fail_count <= mismatches;
        open_count <= due_rsp.size();
    end

endmodule

>>> tb/sv/tb_sorted_request_queue_top.sv
// Testbench top of the sorted request queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sorted_request_queue_top;

    localparam int DEPTH = 16;

    // Kind code 3 is not an operation; the queue must leave its contents alone.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Length of the long receiver hold-off used to fill the queue and stall its input.
    localparam int LONG_HOLD = 80;

    // Beats per random phase and per pressure burst.
    localparam int PHASE_BEATS = 420;
    localparam int BURST_BEATS = 30;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    sortq_pkg::req_t req       = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    sortq_pkg::rsp_t rsp;

    int fail_count;
    int open_count;

    // Idle rates in percent. The sender rate is only used by the stimulus process;
    // the receiver rate is handed over with a nonblocking write.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Each increment asks the receiver process for one long hold-off.
    int hold_requests = 0;
    int hold_seen;
    int hold_left;

    // Swings the random mix between filling and draining the queue, so that both
    // the full and the empty queue are reached many times.
    bit fill_bias = 1'b1;

    sorted_request_queue_top #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sorted_request_queue_checker #(
        .DEPTH (DEPTH)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    always #5 clk = ~clk;

    // Response side. A requested hold-off keeps ready low while a countdown from
    // LONG_HOLD runs out; otherwise ready follows the current idle rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic sortq_pkg::req_t make_req(logic [1:0] kind,
                                                 logic [sortq_pkg::TAG_W-1:0] tag,
                                                 logic [sortq_pkg::SECTOR_W-1:0] start_sector,
                                                 logic [sortq_pkg::COUNT_W-1:0] sector_count,
                                                 logic is_write);
        sortq_pkg::req_t r;
        r.kind         = kind;
        r.tag          = tag;
        r.start_sector = start_sector;
        r.sector_count = sector_count;
        r.is_write     = is_write;
        return r;
    endfunction

    // One random request beat. Small tags make removes hit and create duplicate tags;
    // small sectors and counts make equal end sectors common; the top of the sector
    // range with a large count carries the end sector into its 49th bit.
    function automatic sortq_pkg::req_t random_request();
        sortq_pkg::req_t r;
        int              roll;
        if ($urandom_range(39) == 0)
        begin
            fill_bias = ~fill_bias;
        end
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            r.kind = KIND_UNUSED;
        end
        else if (roll < 18)
        begin
            r.kind = sortq_pkg::KIND_REMOVE;
        end
        else if (roll < (fill_bias ? 78 : 43))
        begin
            r.kind = sortq_pkg::KIND_ADD;
        end
        else
        begin
            r.kind = sortq_pkg::KIND_DISPATCH;
        end
        r.tag = $urandom_range(1) ? sortq_pkg::TAG_W'($urandom_range(7))
                                  : sortq_pkg::TAG_W'($urandom_range(255));
        case ($urandom_range(2))
            0:       r.start_sector = sortq_pkg::SECTOR_W'($urandom_range(31));
            1:       r.start_sector = sortq_pkg::SECTOR_W'({$urandom(), $urandom()});
            default: r.start_sector = {sortq_pkg::SECTOR_W{1'b1}}
                                      - sortq_pkg::SECTOR_W'($urandom_range(3));
        endcase
        case ($urandom_range(2))
            0:       r.sector_count = sortq_pkg::COUNT_W'($urandom_range(3));
            1:       r.sector_count = sortq_pkg::COUNT_W'($urandom_range(65535));
            default: r.sector_count = {sortq_pkg::COUNT_W{1'b1}};
        endcase
        r.is_write = 1'($urandom_range(1));
        return r;
    endfunction

    // Offers one request beat and returns at the edge where it is taken. Idle cycles
    // come first, so valid is never lowered and raised again within one step.
    task automatic send_req(input sortq_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
    endtask

    // Asks for a long receiver hold-off and streams adds without gaps, so the
    // queue fills, adds get refused, and the input side is stalled for a while.
    task automatic pressure_burst();
        int saved_pct;
        int n;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        for (n = 0; n < BURST_BEATS; n++)
        begin
            send_req(make_req(sortq_pkg::KIND_ADD, sortq_pkg::TAG_W'($urandom_range(255)),
                              sortq_pkg::SECTOR_W'({$urandom(), $urandom()}),
                              sortq_pkg::COUNT_W'($urandom_range(65535)),
                              1'($urandom_range(1))));
        end
        send_idle_pct = saved_pct;
    endtask

    task automatic random_phase(input int beats);
        int n;
        for (n = 0; n < beats; n++)
        begin
            send_req(random_request());
        end
    endtask

    initial
    begin
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the empty queue for every operation, the extremes of the
        // fields, equal end sectors, duplicate tags, an absent tag, the unused kind,
        // and a full queue that refuses adds.
        send_req(make_req(sortq_pkg::KIND_DISPATCH, 8'h00, '0, '0, 1'b0));
        send_req(make_req(sortq_pkg::KIND_REMOVE, 8'h00, '0, '0, 1'b0));
        send_req(make_req(KIND_UNUSED, 8'h00, '0, '0, 1'b0));
        send_req(make_req(sortq_pkg::KIND_ADD, 8'h00, '0, '0, 1'b0));
        send_req(make_req(sortq_pkg::KIND_ADD, 8'hFF, {sortq_pkg::SECTOR_W{1'b1}},
                          {sortq_pkg::COUNT_W{1'b1}}, 1'b1));
        // Two requests that both end at sector 5 must leave in arrival order.
        send_req(make_req(sortq_pkg::KIND_ADD, 8'h11, 48'd5, 16'd0, 1'b0));
        send_req(make_req(sortq_pkg::KIND_ADD, 8'h12, 48'd3, 16'd2, 1'b1));
        // A second entry with tag 0x11; the remove must take only the lower one.
        send_req(make_req(sortq_pkg::KIND_ADD, 8'h11, 48'd100, 16'd1, 1'b1));
        send_req(make_req(sortq_pkg::KIND_REMOVE, 8'h11, '0, '0, 1'b0));
        send_req(make_req(sortq_pkg::KIND_REMOVE, 8'h42, '0, '0, 1'b0));
        send_req(make_req(KIND_UNUSED, 8'hFF, {sortq_pkg::SECTOR_W{1'b1}},
                          {sortq_pkg::COUNT_W{1'b1}}, 1'b1));
        // Fill to the top and push two more adds, which must be refused.
        for (n = 0; n < DEPTH - 2; n++)
        begin
            send_req(make_req(sortq_pkg::KIND_ADD, sortq_pkg::TAG_W'(8'h20 + n),
                              sortq_pkg::SECTOR_W'(1000 - 7 * n),
                              sortq_pkg::COUNT_W'(n), n[0]));
        end
        send_req(make_req(sortq_pkg::KIND_DISPATCH, 8'h00, '0, '0, 1'b0));
        send_req(make_req(sortq_pkg::KIND_DISPATCH, 8'h00, '0, '0, 1'b0));

        // Slow receiver, fairly busy sender, with one long hold-off at the start.
        send_idle_pct = 38;
        recv_idle_pct <= 73;
        pressure_burst();
        random_phase(PHASE_BEATS);

        // Slow sender, fairly busy receiver.
        send_idle_pct = 73;
        recv_idle_pct <= 38;
        random_phase(PHASE_BEATS);

        // Back to back on both sides, again with a long hold-off first.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        pressure_burst();
        random_phase(PHASE_BEATS);

        req_valid <= 1'b0;

        // Let the last beat be counted, drain every response, then leave a margin
        // before the verdict.
        @(posedge clk);
        while (open_count != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: ends the run with a failure if it has not finished by then.
    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule
